>>> rtl/pmi_pkg.sv
// shared constants, state type and helpers of the minimum image vector block
package pmi_pkg;

  localparam int PACK_W    = 21;
  localparam int REG_W     = 3 * PACK_W;
  localparam int CAP_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 28;
  localparam int MUL_W     = 30;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = PROD_W;
  localparam int WRAP_W    = 23;
  localparam int DR_W      = WRAP_W + 1;
  localparam int V_W       = 28;
  localparam int SQ_IN_W   = 50;
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int BEST_W    = 58;
  localparam int LEN_W     = 43;
  localparam int BND_W     = CAP_W;
  localparam int CNT_W     = BND_W + 1;
  localparam int N_VEC     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_LAT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RCP_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RCP_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RCP_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAP   = 3'd6;

  localparam logic [REG_W-1:0] RST_LAT_A = 63'd1024;
  localparam logic [REG_W-1:0] RST_LAT_B = 63'd2147483648;
  localparam logic [REG_W-1:0] RST_LAT_C = 63'd4503599627370496;
  localparam logic [REG_W-1:0] RST_RCP_A = 63'd262144;
  localparam logic [REG_W-1:0] RST_RCP_B = 63'd549755813888;
  localparam logic [REG_W-1:0] RST_RCP_C = 63'd1152921504606846976;
  localparam logic [CAP_W-1:0] RST_CAP   = 4'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_FRAC, S_WRAP, S_DIFF, S_DSQ, S_RSTART, S_RWAIT, S_ROWSQ,
    S_LSTART, S_LWAIT, S_BOUND, S_OFFS, S_INIT, S_IMSUM, S_IMSQ, S_IMCMP, S_OUT
  } state_e;

  function automatic logic signed [PACK_W-1:0] comp(logic [REG_W-1:0] v, logic [1:0] k);
    logic signed [PACK_W-1:0] r;
    case (k)
      2'd0:    r = v[0*PACK_W +: PACK_W];
      2'd1:    r = v[1*PACK_W +: PACK_W];
      default: r = v[2*PACK_W +: PACK_W];
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pmi_if.sv
// handshake channels of the minimum image vector block
interface pmi_item_if #(parameter int COORD_BITS = 21);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

interface pmi_result_if #(parameter int COORD_BITS = 21);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] image_x;
  logic signed [COORD_BITS-1:0] image_y;
  logic signed [COORD_BITS-1:0] image_z;
  logic [42:0]                  length_sq;
  modport source (output valid, image_x, image_y, image_z, length_sq, input ready);
  modport sink (input valid, image_x, image_y, image_z, length_sq, output ready);
endinterface

interface pmi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [62:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pmi_sqrt.sv
// iterative ceiling square root, two operand bits per cycle
module pmi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] value_i,
  output logic        done_o,
  output logic [24:0] root_o
);
  import pmi_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CW    = $clog2(ROOT_W);

  logic [SQ_IN_W-1:0] val_q;
  logic [REM_W-1:0]   rem_q, rem_sh, trial, rem_n;
  logic [ROOT_W-1:0]  root_q, root_n, res_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;

  assign rem_sh = {rem_q[REM_W-3:0], val_q[SQ_IN_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_comb begin
    if (rem_sh >= trial) begin
      rem_n  = rem_sh - trial;
      root_n = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh;
      root_n = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= rem_n;
      root_q <= root_n;
      if (cnt_q == CW'(ROOT_W - 1)) res_q <= root_n + ROOT_W'(rem_n != '0);
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

>>> rtl/periodic_minimum_image_vector.sv
// Minimum periodic image of the difference of two points in a triclinic cell.
// One item at a time on a single shared 30x30 multiplier and a 2-bit-per-cycle
// square root unit. The scan covers (2*na+1)*(2*nb+1)*(2*nc+1) images, with
// the per-axis bounds na, nb, nc; each product is registered before it is
// accumulated.
module periodic_minimum_image_vector #(
  parameter int MAX_IMAGE_MULT = 15,
  parameter int COORD_BITS     = 21
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pmi_cfg_if.sink      cfg_i,
  pmi_item_if.sink     in_i,
  pmi_result_if.source out_o
);
  import pmi_pkg::*;

  localparam int C_HI = (1 << (COORD_BITS - 1)) - 1;
  localparam int C_LO = -(1 << (COORD_BITS - 1));

  state_e state_q, state_d;
  logic       ph_q, pt_q;
  logic [1:0] i_q, k_q;
  logic       last_i, last_k, acc_first, sq_start, sq_done, all_done;

  logic [REG_W-1:0] vec_q [N_VEC];
  logic [CAP_W-1:0] cap_q, cap_eff;

  logic signed [COORD_BITS-1:0] pin_q [2][3];
  logic [FRAC_W-1:0]            frac_q [2][3];
  logic signed [WRAP_W-1:0]     wrap_q [2][3];
  logic signed [DR_W-1:0]       dr_q [3];
  logic signed [V_W-1:0]        best_q [3], v_q [3], off_q [3][3];
  logic signed [V_W-1:0]        pa_q [3], pb_q [3], pc_q [3];
  logic [BEST_W-1:0]            best_sq_q;
  logic [ROOT_W-1:0]            radius_q, rl_q, sq_root;
  logic [BND_W-1:0]             bnd_q [3];
  logic [CNT_W-1:0]             ca_q, cb_q, cc_q;
  logic signed [ACC_W-1:0]      acc_q, mac_sum, rnd_sum;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]            n_full;
  logic [PROD_W-FRAC_W-1:0]     n_ceil;
  logic [CFG_IDX_W-1:0]         rcp_idx;

  assign last_i  = (i_q == 2'd2);
  assign last_k  = (k_q == 2'd2);
  assign rcp_idx = CFG_IDX_W'(i_q) + REG_RCP_A;
  assign cap_eff = (32'(cap_q) > MAX_IMAGE_MULT) ? CAP_W'(MAX_IMAGE_MULT) : cap_q;
  assign all_done = (ca_q == {bnd_q[0], 1'b0}) && (cb_q == {bnd_q[1], 1'b0}) &&
                    (cc_q == {bnd_q[2], 1'b0});

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q[0] <= RST_LAT_A;
      vec_q[1] <= RST_LAT_B;
      vec_q[2] <= RST_LAT_C;
      vec_q[3] <= RST_RCP_A;
      vec_q[4] <= RST_RCP_B;
      vec_q[5] <= RST_RCP_C;
      cap_q    <= RST_CAP;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_CAP) cap_q <= cfg_i.data[CAP_W-1:0];
      else if (cfg_i.index < REG_CAP) vec_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_FRAC;
      S_FRAC:   if (ph_q && last_k && last_i && pt_q) state_d = S_WRAP;
      S_WRAP:   if (ph_q && last_k && last_i && pt_q) state_d = S_DIFF;
      S_DIFF:   state_d = S_DSQ;
      S_DSQ:    if (ph_q && last_k) state_d = S_RSTART;
      S_RSTART: state_d = S_RWAIT;
      S_RWAIT:  if (sq_done) state_d = S_ROWSQ;
      S_ROWSQ:  if (ph_q && last_k) state_d = S_LSTART;
      S_LSTART: state_d = S_LWAIT;
      S_LWAIT:  if (sq_done) state_d = S_BOUND;
      S_BOUND:  if (ph_q) state_d = last_i ? S_OFFS : S_ROWSQ;
      S_OFFS:   if (ph_q && last_k && last_i) state_d = S_INIT;
      S_INIT:   state_d = S_IMSUM;
      S_IMSUM:  state_d = S_IMSQ;
      S_IMSQ:   if (ph_q && last_k) state_d = S_IMCMP;
      S_IMCMP:  state_d = all_done ? S_OUT : S_IMSUM;
      S_OUT:    if (out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    acc_first = (k_q == 2'd0);
    sq_start  = 1'b0;
    case (state_q)
      S_FRAC: begin
        mul_a = MUL_W'(comp(vec_q[rcp_idx], k_q));
        mul_b = MUL_W'(pin_q[pt_q][k_q]);
      end
      S_WRAP: begin
        mul_a     = MUL_W'({1'b0, frac_q[pt_q][i_q]});
        mul_b     = MUL_W'(comp(vec_q[CFG_IDX_W'(i_q)], k_q));
        acc_first = (i_q == 2'd0);
      end
      S_DSQ: begin
        mul_a = MUL_W'(dr_q[k_q]);
        mul_b = MUL_W'(dr_q[k_q]);
      end
      S_ROWSQ: begin
        mul_a = MUL_W'(comp(vec_q[rcp_idx], k_q));
        mul_b = MUL_W'(comp(vec_q[rcp_idx], k_q));
      end
      S_BOUND: begin
        mul_a = MUL_W'({1'b0, radius_q});
        mul_b = MUL_W'({1'b0, rl_q});
      end
      S_OFFS: begin
        mul_a = MUL_W'({1'b0, bnd_q[i_q]});
        mul_b = MUL_W'(comp(vec_q[CFG_IDX_W'(i_q)], k_q));
      end
      S_IMSQ: begin
        mul_a = MUL_W'(v_q[k_q]);
        mul_b = MUL_W'(v_q[k_q]);
      end
      S_RSTART, S_LSTART: sq_start = 1'b1;
      default: ;
    endcase
  end

  assign mac_sum = (acc_first ? ACC_W'(0) : acc_q) + prod_q;
  assign rnd_sum = mac_sum + ACC_W'(1 << (FRAC_W - 1));
  assign n_full  = prod_q + PROD_W'((1 << FRAC_W) - 1);
  assign n_ceil  = n_full[PROD_W-1:FRAC_W];

  pmi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (acc_q[SQ_IN_W-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 1'b0;
      pt_q    <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_FRAC, S_WRAP, S_DSQ, S_ROWSQ, S_BOUND, S_OFFS, S_IMSQ: ph_q <= ~ph_q;
        default: ph_q <= 1'b0;
      endcase
      if (ph_q) begin
        case (state_q)
          S_FRAC: begin
            k_q <= last_k ? 2'd0 : k_q + 2'd1;
            if (last_k) begin
              i_q <= last_i ? 2'd0 : i_q + 2'd1;
              if (last_i) pt_q <= ~pt_q;
            end
          end
          S_OFFS: begin
            k_q <= last_k ? 2'd0 : k_q + 2'd1;
            if (last_k) i_q <= last_i ? 2'd0 : i_q + 2'd1;
          end
          S_WRAP: begin
            i_q <= last_i ? 2'd0 : i_q + 2'd1;
            if (last_i) begin
              k_q <= last_k ? 2'd0 : k_q + 2'd1;
              if (last_k) pt_q <= ~pt_q;
            end
          end
          S_DSQ, S_ROWSQ, S_IMSQ: k_q <= last_k ? 2'd0 : k_q + 2'd1;
          S_BOUND: i_q <= last_i ? 2'd0 : i_q + 2'd1;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: if (in_i.valid) begin
        pin_q[0][0] <= in_i.first_x;
        pin_q[0][1] <= in_i.first_y;
        pin_q[0][2] <= in_i.first_z;
        pin_q[1][0] <= in_i.second_x;
        pin_q[1][1] <= in_i.second_y;
        pin_q[1][2] <= in_i.second_z;
      end
      S_FRAC: if (ph_q) begin
        acc_q <= mac_sum;
        if (last_k) frac_q[pt_q][i_q] <= mac_sum[FRAC_W-1:0];
      end
      S_WRAP: if (ph_q) begin
        acc_q <= mac_sum;
        if (last_i) wrap_q[pt_q][k_q] <= rnd_sum[FRAC_W +: WRAP_W];
      end
      S_DIFF: for (int kk = 0; kk < 3; kk++)
        dr_q[kk] <= DR_W'(wrap_q[1][kk]) - DR_W'(wrap_q[0][kk]);
      S_DSQ: if (ph_q) begin
        acc_q <= mac_sum;
        if (last_k) begin
          best_sq_q <= mac_sum[BEST_W-1:0];
          for (int kk = 0; kk < 3; kk++) best_q[kk] <= V_W'(dr_q[kk]);
        end
      end
      S_RWAIT: if (sq_done) radius_q <= sq_root;
      S_ROWSQ: if (ph_q) acc_q <= mac_sum;
      S_LWAIT: if (sq_done) rl_q <= sq_root;
      S_BOUND: if (ph_q)
        bnd_q[i_q] <= (n_ceil > (PROD_W - FRAC_W)'(cap_eff)) ? cap_eff : n_ceil[BND_W-1:0];
      S_OFFS: if (ph_q) off_q[i_q][k_q] <= prod_q[V_W-1:0];
      S_INIT: begin
        ca_q <= '0;
        cb_q <= '0;
        cc_q <= '0;
        for (int kk = 0; kk < 3; kk++) begin
          pa_q[kk] <= -off_q[0][kk];
          pb_q[kk] <= -off_q[1][kk];
          pc_q[kk] <= -off_q[2][kk];
        end
      end
      S_IMSUM: for (int kk = 0; kk < 3; kk++)
        v_q[kk] <= V_W'(dr_q[kk]) + pa_q[kk] + pb_q[kk] + pc_q[kk];
      S_IMSQ: if (ph_q) acc_q <= mac_sum;
      S_IMCMP: begin
        if (acc_q[BEST_W-1:0] < best_sq_q) begin
          best_sq_q <= acc_q[BEST_W-1:0];
          for (int kk = 0; kk < 3; kk++) best_q[kk] <= v_q[kk];
        end
        if (cc_q != {bnd_q[2], 1'b0}) begin
          cc_q <= cc_q + 1'b1;
          for (int kk = 0; kk < 3; kk++)
            pc_q[kk] <= pc_q[kk] + V_W'(comp(vec_q[REG_LAT_C], 2'(kk)));
        end else begin
          cc_q <= '0;
          for (int kk = 0; kk < 3; kk++) pc_q[kk] <= -off_q[2][kk];
          if (cb_q != {bnd_q[1], 1'b0}) begin
            cb_q <= cb_q + 1'b1;
            for (int kk = 0; kk < 3; kk++)
              pb_q[kk] <= pb_q[kk] + V_W'(comp(vec_q[REG_LAT_B], 2'(kk)));
          end else begin
            cb_q <= '0;
            for (int kk = 0; kk < 3; kk++) pb_q[kk] <= -off_q[1][kk];
            if (ca_q != {bnd_q[0], 1'b0}) begin
              ca_q <= ca_q + 1'b1;
              for (int kk = 0; kk < 3; kk++)
                pa_q[kk] <= pa_q[kk] + V_W'(comp(vec_q[REG_LAT_A], 2'(kk)));
            end
          end
        end
      end
      default: ;
    endcase
  end

  function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [V_W-1:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > V_W'(C_HI)) r = COORD_BITS'(C_HI);
    else if (v < V_W'(C_LO)) r = COORD_BITS'(C_LO);
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_OUT);
  assign out_o.image_x   = sat_coord(best_q[0]);
  assign out_o.image_y   = sat_coord(best_q[1]);
  assign out_o.image_z   = sat_coord(best_q[2]);
  assign out_o.length_sq = (|best_sq_q[BEST_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                        : best_sq_q[LEN_W-1:0];

endmodule
